// ===== sv/differential_drive_pid_mixer_assert.svh =====
// Assertion macros for the differential drive mixer.
// Each macro takes a label, the clock, the reset, a trigger and a consequence.
`ifndef DIFFERENTIAL_DRIVE_PID_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PID_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define DDPM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("differential_drive_pid_mixer: same-cycle check failed");
`define DDPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("differential_drive_pid_mixer: next-cycle check failed");
`else
`define DDPM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DDPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/ddpm_pkg.sv =====
`default_nettype none
package ddpm_pkg;

   // Port and field widths
   localparam int CNT_W      = 32;
   localparam int GAIN_W     = 16;
   localparam int SPD_CFG_W  = 8;
   localparam int RPT_W      = 17;
   localparam int DUTY_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;

   // Bit positions of the request word
   localparam int REQ_FWD_BIT   = 0;
   localparam int REQ_BACK_BIT  = 1;
   localparam int REQ_LEFT_BIT  = 2;
   localparam int REQ_RIGHT_BIT = 3;
   localparam int REQ_LC_LSB    = 4;
   localparam int REQ_RC_LSB    = REQ_LC_LSB + CNT_W;

   // Datapath widths
   localparam int SPD_W   = 11;                 // mixed speed, up to +-510
   localparam int PROD_W  = CNT_W + RPT_W + 1;  // signed delta times tick size
   localparam int DIFF_W  = PROD_W + 1;
   localparam int ERR_W   = 32;
   localparam int SUM_W   = 24;
   localparam int SACC_W  = ERR_W + 1;
   localparam int DER_W   = ERR_W + 1;
   localparam int ACC_W   = 52;
   localparam int FRAC_W  = 24;                 // Q8.8 gain times Q16 error
   localparam int CORR_W  = ACC_W - FRAC_W;
   localparam int SCALE_W = 11;
   localparam int SPRD_W  = SPD_W + SCALE_W;
   localparam int SCL_W   = SPRD_W - 8;
   localparam int OUT_W   = CORR_W + 1;

   localparam int RIGHT_SCALE_Q8 = 256;
   localparam int SUM_LIMIT      = 6553600;     // 100 revolutions in Q16
   localparam int DUTY_LIMIT     = 255;

   localparam logic signed [SCALE_W-1:0] RIGHT_SCALE = SCALE_W'(RIGHT_SCALE_Q8);
   localparam logic signed [SACC_W-1:0]  SUM_HI      = SACC_W'(SUM_LIMIT);
   localparam logic signed [SACC_W-1:0]  SUM_LO      = -SUM_HI;
   localparam logic signed [OUT_W-1:0]   DUTY_HI     = OUT_W'(DUTY_LIMIT);
   localparam logic signed [OUT_W-1:0]   DUTY_LO     = -DUTY_HI;
   localparam logic [RPT_W-1:0]          RPT_RESET   = RPT_W'(65536);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_BASE_SPEED  = 3'd3,
      CSR_TURN_OFFSET = 3'd4,
      CSR_PIVOT_SPEED = 3'd5,
      CSR_LEFT_RPT    = 3'd6,
      CSR_RIGHT_RPT   = 3'd7
   } csr_index_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_ERR  = 8'b0000_0100,
      ST_SUM  = 8'b0000_1000,
      ST_PROD = 8'b0001_0000,
      ST_ACC  = 8'b0010_0000,
      ST_CORR = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic err;
      logic sum;
      logic prod;
      logic acc;
      logic corr;
      logic fin;
   } ddpm_cmd_type;

   typedef struct packed {
      logic in_straight;
      logic out_free;
   } ddpm_sts_type;

endpackage
`default_nettype wire

// ===== sv/ddpm_ctrl.sv =====
`default_nettype none
module ddpm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire ddpm_pkg::ddpm_sts_type sts,
   output ddpm_pkg::ddpm_cmd_type     cmd
);
   import ddpm_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.in_straight ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_CORR;
         end
         ST_CORR: begin
            cmd.corr = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold here until the output register can take the result.
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/ddpm_dpath.sv =====
`default_nettype none
module ddpm_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [ddpm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [ddpm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [ddpm_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ddpm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire ddpm_pkg::ddpm_cmd_type            cmd,
   output ddpm_pkg::ddpm_sts_type                 sts
);
   import ddpm_pkg::*;

   // Configuration registers
   logic signed [GAIN_W-1:0]  prop_ff, integ_ff, deriv_ff;
   logic [SPD_CFG_W-1:0]      base_ff, turn_ff, pivot_ff;
   logic [RPT_W-1:0]          lrpt_ff, rrpt_ff;

   // Loop state
   logic [CNT_W-1:0]          prev_left_ff, prev_right_ff;
   logic signed [SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]   last_error_ff;

   // Working registers
   logic                      straight_ff;
   logic signed [SPD_W-1:0]   sl_ff, sr_ff, sl_in, sr_in;
   logic signed [CNT_W-1:0]   dl_ff, dr_ff;
   logic signed [PROD_W-1:0]  pl_ff, pr_ff, pl_in, pr_in;
   logic signed [SCL_W-1:0]   srs_ff, srs_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DER_W-1:0]   der_ff, der_in;
   logic signed [ACC_W-1:0]   p_ff, i_ff, d_ff, acc_ff;
   logic signed [CORR_W-1:0]  corr_ff, corr_in;
   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic                      fwd, bwd, lft, rgt, moving, turning;
   logic [CNT_W-1:0]          lc, rc;
   logic signed [SPD_W-1:0]   base_s, off_s, piv_s, dir_base, off_side, dir_off;
   logic signed [SPRD_W-1:0]  sr_prod, sr_bias;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [SACC_W-1:0]  sacc;
   logic signed [ACC_W-1:0]   acc_bias;
   logic signed [OUT_W-1:0]   left_spd, right_spd;

   function automatic logic [2*DUTY_W-1:0] drive_pair(input logic signed [OUT_W-1:0] spd);
      logic [DUTY_W-1:0]       fwd_d;
      logic [DUTY_W-1:0]       rev_d;
      logic signed [OUT_W-1:0] mag;
      mag = -spd;
      if (spd > DUTY_HI) begin
         fwd_d = DUTY_HI[DUTY_W-1:0];
         rev_d = '0;
      end else if (spd < DUTY_LO) begin
         fwd_d = '0;
         rev_d = DUTY_HI[DUTY_W-1:0];
      end else if (!spd[OUT_W-1]) begin
         fwd_d = spd[DUTY_W-1:0];
         rev_d = '0;
      end else begin
         fwd_d = '0;
         rev_d = mag[DUTY_W-1:0];
      end
      return {rev_d, fwd_d};
   endfunction

   assign fwd     = req_tdata[REQ_FWD_BIT];
   assign bwd     = req_tdata[REQ_BACK_BIT];
   assign lft     = req_tdata[REQ_LEFT_BIT];
   assign rgt     = req_tdata[REQ_RIGHT_BIT];
   assign lc      = req_tdata[REQ_LC_LSB +: CNT_W];
   assign rc      = req_tdata[REQ_RC_LSB +: CNT_W];
   assign moving  = fwd | bwd;
   assign turning = lft | rgt;

   // Button mix
   always_comb begin
      base_s   = $signed({{(SPD_W-SPD_CFG_W){1'b0}}, base_ff});
      off_s    = $signed({{(SPD_W-SPD_CFG_W){1'b0}}, turn_ff});
      piv_s    = $signed({{(SPD_W-SPD_CFG_W){1'b0}}, pivot_ff});
      dir_base = fwd ? base_s : -base_s;
      off_side = lft ? -off_s : off_s;
      dir_off  = fwd ? off_side : -off_side;
      if (moving) begin
         sl_in = turning ? dir_base + dir_off : dir_base;
         sr_in = turning ? dir_base - dir_off : dir_base;
      end else if (turning) begin
         sl_in = lft ? piv_s : -piv_s;
         sr_in = lft ? -piv_s : piv_s;
      end else begin
         sl_in = '0;
         sr_in = '0;
      end
   end

   // Revolutions per wheel, and the right-side trim scale rounded toward zero
   always_comb begin
      pl_in   = PROD_W'(dl_ff) * PROD_W'($signed({1'b0, lrpt_ff}));
      pr_in   = PROD_W'(dr_ff) * PROD_W'($signed({1'b0, rrpt_ff}));
      sr_prod = SPRD_W'(sr_ff) * SPRD_W'(RIGHT_SCALE);
      sr_bias = sr_prod + (sr_prod[SPRD_W-1] ? SPRD_W'(255) : SPRD_W'(0));
      srs_in  = sr_bias[SPRD_W-1:8];
   end

   // Error saturates to 32 bits: it fits when all bits above bit 30 agree
   always_comb begin
      diff = DIFF_W'(pl_ff) - DIFF_W'(pr_ff);
      if ((&diff[DIFF_W-1:ERR_W-1]) || !(|diff[DIFF_W-1:ERR_W-1])) begin
         err_in = diff[ERR_W-1:0];
      end else if (diff[DIFF_W-1]) begin
         err_in = {1'b1, {(ERR_W-1){1'b0}}};
      end else begin
         err_in = {1'b0, {(ERR_W-1){1'b1}}};
      end
   end

   always_comb begin
      sacc   = SACC_W'(error_sum_ff) + SACC_W'(err_ff);
      der_in = DER_W'(err_ff) - DER_W'(last_error_ff);
      if (sacc > SUM_HI) begin
         error_sum_in = SUM_HI[SUM_W-1:0];
      end else if (sacc < SUM_LO) begin
         error_sum_in = SUM_LO[SUM_W-1:0];
      end else begin
         error_sum_in = sacc[SUM_W-1:0];
      end
   end

   // Drop the fraction, rounding toward zero
   always_comb begin
      acc_bias = acc_ff + (acc_ff[ACC_W-1] ? $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
                                           : ACC_W'(0));
      corr_in  = acc_bias[ACC_W-1:FRAC_W];
   end

   always_comb begin
      if (straight_ff) begin
         left_spd  = OUT_W'(sl_ff) - OUT_W'(corr_ff);
         right_spd = OUT_W'(srs_ff) + OUT_W'(corr_ff);
      end else begin
         left_spd  = OUT_W'(sl_ff);
         right_spd = OUT_W'(sr_ff);
      end
      rsp_tdata_in = {drive_pair(right_spd), drive_pair(left_spd)};
   end

   // Registers with reset: configuration, loop state, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff       <= '0;
         integ_ff      <= '0;
         deriv_ff      <= '0;
         base_ff       <= '0;
         turn_ff       <= '0;
         pivot_ff      <= '0;
         lrpt_ff       <= RPT_RESET;
         rrpt_ff       <= RPT_RESET;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index_type'(csr_addr))
               CSR_PROP_GAIN:   prop_ff  <= csr_wdata[GAIN_W-1:0];
               CSR_INTEG_GAIN:  integ_ff <= csr_wdata[GAIN_W-1:0];
               CSR_DERIV_GAIN:  deriv_ff <= csr_wdata[GAIN_W-1:0];
               CSR_BASE_SPEED:  base_ff  <= csr_wdata[SPD_CFG_W-1:0];
               CSR_TURN_OFFSET: turn_ff  <= csr_wdata[SPD_CFG_W-1:0];
               CSR_PIVOT_SPEED: pivot_ff <= csr_wdata[SPD_CFG_W-1:0];
               CSR_LEFT_RPT:    lrpt_ff  <= csr_wdata[RPT_W-1:0];
               CSR_RIGHT_RPT:   rrpt_ff  <= csr_wdata[RPT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            prev_left_ff  <= lc;
            prev_right_ff <= rc;
            if (!sts.in_straight) begin
               error_sum_ff  <= '0;
               last_error_ff <= '0;
            end
         end
         if (cmd.sum) begin
            error_sum_ff  <= error_sum_in;
            last_error_ff <= err_ff;
         end
         if (cmd.fin) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         straight_ff <= sts.in_straight;
         sl_ff       <= sl_in;
         sr_ff       <= sr_in;
         dl_ff       <= $signed(lc - prev_left_ff);
         dr_ff       <= $signed(rc - prev_right_ff);
      end
      if (cmd.mul) begin
         pl_ff  <= pl_in;
         pr_ff  <= pr_in;
         srs_ff <= srs_in;
      end
      if (cmd.err) begin
         err_ff <= err_in;
      end
      if (cmd.sum) begin
         der_ff <= der_in;
      end
      if (cmd.prod) begin
         p_ff <= ACC_W'(prop_ff) * ACC_W'(err_ff);
         i_ff <= ACC_W'(integ_ff) * ACC_W'(error_sum_ff);
         d_ff <= ACC_W'(deriv_ff) * ACC_W'(der_ff);
      end
      if (cmd.acc) begin
         acc_ff <= p_ff + i_ff + d_ff;
      end
      if (cmd.corr) begin
         corr_ff <= corr_in;
      end
      if (cmd.fin) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign sts.in_straight = moving & ~turning;
   assign sts.out_free    = ~rsp_tvalid_ff | rsp_tready;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_tdata       = rsp_tdata_ff;

endmodule
`default_nettype wire

// ===== sv/differential_drive_pid_mixer.sv =====
`default_nettype none
// Channel    Dir  Handshake              Word contents, lowest bit first
// req_       in   req_tvalid/req_tready  fwd, back, left, right, left_count, right_count
// rsp_       out  rsp_tvalid/rsp_tready  left_fwd, left_rev, right_fwd, right_rev duty
// csr_       in   csr_wen                register index csr_addr, value csr_wdata
//
// A straight-driving word (forward or backward held, no turn button) passes in order
// through the dependent chain of the one PID datapath: wheel products, error saturation,
// integral clamp, gain products, sum, rounding and the final mix before the next
// acceptance; any other word goes from acceptance directly to the final mix.
// Reset is synchronous and active high; it restores the gains, speeds and loop state.
// A result waiting in the output register does not stop the next word from being
// taken; only the final step waits for that register to empty.
`include "differential_drive_pid_mixer_assert.svh"
module differential_drive_pid_mixer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Register write port; index follows the register list
   input  wire logic                              csr_wen,
   input  wire logic [ddpm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [ddpm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // Input words
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [0] fwd_pressed, [1] back_pressed, [2] left_pressed, [3] right_pressed,
   // [35:4] left_count, [67:36] right_count, [71:68] zero
   input  wire logic [ddpm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result words
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] left_fwd_duty, [15:8] left_rev_duty,
   // [23:16] right_fwd_duty, [31:24] right_rev_duty
   output logic [ddpm_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import ddpm_pkg::*;

   ddpm_cmd_type ctl_cmd;
   ddpm_sts_type ctl_sts;

   // The controller steps each word through the datapath stages; a word that is
   // not driving straight skips the PID stages and goes directly to the output.
   ddpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (ctl_sts),
      .cmd        (ctl_cmd)
   );

   // The datapath holds the registers, the loop state and the output register.
   ddpm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (ctl_cmd),
      .sts        (ctl_sts)
   );

   // Only one word is in flight: after an acceptance the input side closes.
   `DDPM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // The final step never overwrites a result that has not been taken.
   `DDPM_ASSERT_SAME(a_no_overwrite, clock, reset, ctl_cmd.fin, ctl_sts.out_free)
   // Finishing a word reopens the input side and presents the result.
   `DDPM_ASSERT_NEXT(a_fin_reopens, clock, reset, ctl_cmd.fin, req_tready && rsp_tvalid)

endmodule
`default_nettype wire
